@@ hdl/dmc_pkg.sv @@
// Shared types and constants for the direct-mapped write-through cache.
`timescale 1ns / 1ps

package dmc_pkg;

  localparam int AddrWidthDefault  = 32;
  localparam int IndexBitsDefault  = 6;
  localparam int OffsetBitsDefault = 3;

  localparam int CountW     = 32;
  localparam int InAddrW    = 32;
  localparam int ByteW      = 8;
  localparam int InLineW    = 64;
  localparam int InDataW    = 104;
  localparam int OutDataW   = 112;

  typedef enum logic [0:0] {
    ACT_LOAD  = 1'b0,
    ACT_STORE = 1'b1
  } action_t;

  typedef struct packed {
    logic fire;
    logic hit;
    logic evict;
  } dmc_event_t;

  typedef struct packed {
    logic [CountW-1:0] hit_total;
    logic [CountW-1:0] miss_total;
    logic [CountW-1:0] eviction_total;
  } dmc_totals_t;

endpackage

@@ hdl/direct_mapped_write_through_cache_top.sv @@
// Top level of the direct-mapped write-through byte cache.
//
//  Channel   Dir  tdata / tuser fields (lowest bit first)
//  s_axis    in   tuser: action; tdata: byte_address, store_byte, memory_line
//  m_axis    out  tdata: read_byte, was_hit, was_eviction, memory_write,
//                 hit_total, miss_total, eviction_total, zero fill
//
// One beat is accepted per cycle while the output is not stalled.
// The tag and data memory is read when a beat is accepted and written back when
// the beat leaves the lookup stage, with a bypass for back-to-back accesses.
// Reset clears the valid bits, the counters and both stages at once.
// A stalled output register holds the lookup stage, which then holds the input.
`timescale 1ns / 1ps

module direct_mapped_write_through_cache_top #(
  parameter int ADDRESS_WIDTH = dmc_pkg::AddrWidthDefault,
  parameter int INDEX_BITS    = dmc_pkg::IndexBitsDefault,
  parameter int OFFSET_BITS   = dmc_pkg::OffsetBitsDefault
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // action
  input  logic [0:0]                   s_axis_tuser,
  // byte_address[31:0], store_byte[39:32], memory_line[103:40]
  input  logic [dmc_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // read_byte[7:0], was_hit[8], was_eviction[9], memory_write[10],
  // hit_total[42:11], miss_total[74:43], eviction_total[106:75], zero[111:107]
  output logic [dmc_pkg::OutDataW-1:0] m_axis_tdata
);
  import dmc_pkg::*;

  localparam int LineBits  = INDEX_BITS + OFFSET_BITS;
  localparam int TagW      = ADDRESS_WIDTH - LineBits;
  localparam int IdxW      = (INDEX_BITS > 0) ? INDEX_BITS : 1;
  localparam int OffW      = (OFFSET_BITS > 0) ? OFFSET_BITS : 1;
  localparam int LineCount = 1 << INDEX_BITS;
  localparam int LineBytes = 1 << OFFSET_BITS;
  localparam int LineW     = ByteW * LineBytes;
  localparam int ShiftW    = OffW + 3;
  localparam int EntryW    = TagW + LineW;

  // Input beat decode.
  logic                     in_fire;
  logic [ADDRESS_WIDTH-1:0] in_addr;
  logic [IdxW-1:0]          in_index;
  logic [OffW-1:0]          in_offset;
  logic [TagW-1:0]          in_tag;
  logic [LineW-1:0]         in_line;

  assign in_addr = ADDRESS_WIDTH'(s_axis_tdata[InAddrW-1:0]);
  assign in_tag  = in_addr[ADDRESS_WIDTH-1 -: TagW];
  assign in_line = s_axis_tdata[InAddrW+ByteW +: LineW];

  if (INDEX_BITS > 0) begin : g_index
    assign in_index = in_addr[OFFSET_BITS +: IdxW];
  end else begin : g_no_index
    assign in_index = '0;
  end

  if (OFFSET_BITS > 0) begin : g_offset
    assign in_offset = in_addr[OffW-1:0];
  end else begin : g_no_offset
    assign in_offset = '0;
  end

  // Lookup stage registers.
  logic             s1_valid;
  logic             s1_fire;
  action_t          s1_action;
  logic [IdxW-1:0]  s1_index;
  logic [OffW-1:0]  s1_offset;
  logic [TagW-1:0]  s1_tag;
  logic [ByteW-1:0] s1_sbyte;
  logic [LineW-1:0] s1_line;

  // Tag and data memory with registered read, plus valid bits in flops.
  logic [EntryW-1:0]    line_mem [LineCount];
  logic [EntryW-1:0]    mem_q;
  logic [LineCount-1:0] line_valid;

  logic             fwd_sel;
  logic [TagW-1:0]  fwd_tag;
  logic [LineW-1:0] fwd_data;

  // Output register.
  logic                out_valid;
  logic [ByteW-1:0]    out_byte;
  logic                out_hit;
  logic                out_evict;
  logic                out_write;
  dmc_totals_t         out_totals;

  // Lookup logic.
  logic [TagW-1:0]   cur_tag;
  logic [LineW-1:0]  cur_data;
  logic              cur_valid;
  logic              hit;
  logic              evict;
  logic [LineW-1:0]  base_data;
  logic [LineW-1:0]  new_data;
  logic [LineW-1:0]  shifted;
  logic [ShiftW-1:0] shift_amt;

  dmc_event_t  ev;
  dmc_totals_t totals_next;

  assign s1_fire       = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_fire;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    cur_tag   = fwd_sel ? fwd_tag  : mem_q[EntryW-1 -: TagW];
    cur_data  = fwd_sel ? fwd_data : mem_q[LineW-1:0];
    cur_valid = line_valid[s1_index];
    hit       = cur_valid && (cur_tag == s1_tag);
    evict     = cur_valid && !hit;
    base_data = hit ? cur_data : s1_line;
    for (int b = 0; b < LineBytes; b++) begin
      if ((s1_action == ACT_STORE) && (s1_offset == OffW'(b))) begin
        new_data[b*ByteW +: ByteW] = s1_sbyte;
      end else begin
        new_data[b*ByteW +: ByteW] = base_data[b*ByteW +: ByteW];
      end
    end
    shift_amt = {s1_offset, 3'b000};
    shifted   = new_data >> shift_amt;
  end

  assign ev.fire  = s1_fire;
  assign ev.hit   = hit;
  assign ev.evict = evict;

  dmc_counters u_counters (
    .clk         (clk),
    .rst         (rst),
    .ev          (ev),
    .totals_next (totals_next)
  );

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      line_mem[s1_index] <= {s1_tag, new_data};
    end
    if (in_fire) begin
      mem_q <= line_mem[in_index];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_valid <= '0;
    end else if (s1_fire) begin
      line_valid[s1_index] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_sel  <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid <= 1'b1;
        fwd_sel  <= s1_fire && (s1_index == in_index);
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_action <= action_t'(s_axis_tuser);
      s1_index  <= in_index;
      s1_offset <= in_offset;
      s1_tag    <= in_tag;
      s1_sbyte  <= s_axis_tdata[InAddrW +: ByteW];
      s1_line   <= in_line;
      fwd_tag   <= s1_tag;
      fwd_data  <= new_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_byte   <= shifted[ByteW-1:0];
      out_hit    <= hit;
      out_evict  <= evict;
      out_write  <= (s1_action == ACT_STORE);
      out_totals <= totals_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'b00000,
                          out_totals.eviction_total,
                          out_totals.miss_total,
                          out_totals.hit_total,
                          out_write, out_evict, out_hit, out_byte};

  // A result never claims both a hit and an eviction.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_hit && out_evict))
    else $error("hit and eviction flagged together");

  // A beat leaving the lookup stage leaves its line valid.
  a_fill_valid: assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> line_valid[$past(s1_index)])
    else $error("line not valid after access");

  // The input only stalls behind a held lookup stage and a blocked output.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (s1_valid && out_valid && !m_axis_tready))
    else $error("input stalled without downstream back-pressure");

  // Every beat leaving the lookup stage shows up in the output register.
  a_out_loaded: assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> out_valid)
    else $error("result lost between lookup and output");

endmodule

@@ hdl/dmc_counters.sv @@
// Saturating hit, miss and eviction counters of the cache.
`timescale 1ns / 1ps

module dmc_counters (
  input  logic                 clk,
  input  logic                 rst,
  input  dmc_pkg::dmc_event_t  ev,
  output dmc_pkg::dmc_totals_t totals_next
);
  import dmc_pkg::*;

  logic [CountW-1:0] hit_count;
  logic [CountW-1:0] miss_count;
  logic [CountW-1:0] evict_count;

  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] c);
    sat_inc = (c == '1) ? c : c + CountW'(1);
  endfunction

  always_comb begin
    totals_next.hit_total      = (ev.fire && ev.hit) ? sat_inc(hit_count) : hit_count;
    totals_next.miss_total     = (ev.fire && !ev.hit) ? sat_inc(miss_count) : miss_count;
    totals_next.eviction_total = (ev.fire && ev.evict) ? sat_inc(evict_count) : evict_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_count   <= '0;
      miss_count  <= '0;
      evict_count <= '0;
    end else if (ev.fire) begin
      hit_count   <= totals_next.hit_total;
      miss_count  <= totals_next.miss_total;
      evict_count <= totals_next.eviction_total;
    end
  end

endmodule

@@ tb/direct_mapped_write_through_cache_checker.sv @@
// Checker that predicts each cache access and compares it with the output beats.
`timescale 1ns / 1ps

module direct_mapped_write_through_cache_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  input  logic                         s_axis_tready,
  input  logic [0:0]                   s_axis_tuser,
  input  logic [dmc_pkg::InDataW-1:0]  s_axis_tdata,
  input  logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic [dmc_pkg::OutDataW-1:0] m_axis_tdata,
  output int unsigned                  pending,
  output int unsigned                  fail_count
);

  import dmc_pkg::*;

  localparam int IdxW      = IndexBitsDefault;
  localparam int OffW      = OffsetBitsDefault;
  localparam int TagW      = AddrWidthDefault - IdxW - OffW;
  localparam int LineCount = 1 << IdxW;

  typedef struct packed {
    logic [ByteW-1:0]  read_byte;
    logic              was_hit;
    logic              was_eviction;
    logic              memory_write;
    logic [CountW-1:0] hit_total;
    logic [CountW-1:0] miss_total;
    logic [CountW-1:0] eviction_total;
  } access_result_t;

  logic                line_valid [LineCount];
  logic [TagW-1:0]     line_tag   [LineCount];
  logic [InLineW-1:0]  line_data  [LineCount];
  logic [CountW-1:0]   hits;
  logic [CountW-1:0]   misses;
  logic [CountW-1:0]   evictions;
  access_result_t      expected_results [$];

  initial begin
    pending    = 0;
    fail_count = 0;
  end

  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] value);
    return (value == '1) ? value : value + 1'b1;
  endfunction

  task automatic predict_access(input action_t act, input logic [InAddrW-1:0] addr,
                                input logic [ByteW-1:0] store_byte,
                                input logic [InLineW-1:0] memory_line,
                                output access_result_t res);
    logic [IdxW-1:0] idx;
    logic [TagW-1:0] tag;
    int unsigned     shift;
    begin
      idx   = addr[OffW +: IdxW];
      tag   = addr[AddrWidthDefault-1 -: TagW];
      shift = addr[OffW-1:0] * 8;
      res   = '0;
      if (line_valid[idx] && line_tag[idx] == tag) begin
        res.was_hit = 1'b1;
        hits = sat_inc(hits);
      end else begin
        misses = sat_inc(misses);
        if (line_valid[idx]) begin
          res.was_eviction = 1'b1;
          evictions = sat_inc(evictions);
        end
        line_valid[idx] = 1'b1;
        line_tag[idx]   = tag;
        line_data[idx]  = memory_line;
      end
      if (act == ACT_STORE) begin
        line_data[idx][shift +: 8] = store_byte;
      end
      res.read_byte      = line_data[idx][shift +: 8];
      res.memory_write   = (act == ACT_STORE);
      res.hit_total      = hits;
      res.miss_total     = misses;
      res.eviction_total = evictions;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [CountW-1:0] got,
                                 input logic [CountW-1:0] want);
    $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin : monitor
    access_result_t res;
    access_result_t got;
    access_result_t want;
    if (rst) begin
      for (int i = 0; i < LineCount; i++) begin
        line_valid[i] = 1'b0;
      end
      hits      = '0;
      misses    = '0;
      evictions = '0;
      expected_results.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_access(action_t'(s_axis_tuser), s_axis_tdata[31:0], s_axis_tdata[39:32],
                       s_axis_tdata[103:40], res);
        expected_results.push_back(res);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.read_byte      = m_axis_tdata[7:0];
        got.was_hit        = m_axis_tdata[8];
        got.was_eviction   = m_axis_tdata[9];
        got.memory_write   = m_axis_tdata[10];
        got.hit_total      = m_axis_tdata[42:11];
        got.miss_total     = m_axis_tdata[74:43];
        got.eviction_total = m_axis_tdata[106:75];
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected output beat", CountW'(got.read_byte), '0);
        end else begin
          want = expected_results.pop_front();
          if (got.read_byte !== want.read_byte)
            report_mismatch("read_byte", CountW'(got.read_byte), CountW'(want.read_byte));
          if (got.was_hit !== want.was_hit)
            report_mismatch("was_hit", CountW'(got.was_hit), CountW'(want.was_hit));
          if (got.was_eviction !== want.was_eviction)
            report_mismatch("was_eviction", CountW'(got.was_eviction),
                            CountW'(want.was_eviction));
          if (got.memory_write !== want.memory_write)
            report_mismatch("memory_write", CountW'(got.memory_write),
                            CountW'(want.memory_write));
          if (got.hit_total !== want.hit_total)
            report_mismatch("hit_total", got.hit_total, want.hit_total);
          if (got.miss_total !== want.miss_total)
            report_mismatch("miss_total", got.miss_total, want.miss_total);
          if (got.eviction_total !== want.eviction_total)
            report_mismatch("eviction_total", got.eviction_total, want.eviction_total);
        end
      end
    end
    pending <= expected_results.size();
  end

endmodule

@@ tb/tb_direct_mapped_write_through_cache_top.sv @@
// Testbench top: drives cache accesses and output back-pressure, then gives the verdict.
`timescale 1ns / 1ps

module tb_direct_mapped_write_through_cache_top;

  import dmc_pkg::*;

  localparam int RandomAccesses = 1850;

  logic                clk;
  logic                rst           = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [0:0]          s_axis_tuser  = '0;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  int unsigned         pending;
  int unsigned         fail_count;

  direct_mapped_write_through_cache_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  direct_mapped_write_through_cache_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pending       (pending),
    .fail_count    (fail_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin : result_backpressure
    int unsigned ready_len;
    int unsigned stall_len;
    int unsigned r;
    @(negedge clk);
    forever begin
      r = $urandom_range(99);
      ready_len = (r < 10) ? $urandom_range(50, 150) : $urandom_range(1, 6);
      r = $urandom_range(99);
      if (r < 25) stall_len = 0;
      else if (r < 95) stall_len = $urandom_range(1, 3);
      else stall_len = $urandom_range(10, 40);
      m_axis_tready <= 1'b1;
      repeat (ready_len) @(negedge clk);
      if (stall_len > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall_len) @(negedge clk);
      end
    end
  end

  task automatic send_access(input action_t act, input logic [InAddrW-1:0] addr,
                             input logic [ByteW-1:0] store_byte,
                             input logic [InLineW-1:0] memory_line);
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {memory_line, store_byte, addr};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic idle_gap(input int unsigned cycles);
    if (cycles > 0) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin : stimulus
    logic [22:0]        tag_pool [4];
    logic [5:0]         hot_index [4];
    logic [InAddrW-1:0] addr;
    logic [5:0]         idx;
    action_t            act;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_access(ACT_LOAD,  32'h0000_0000, 8'h00, 64'h0000_0000_0000_0000);
    send_access(ACT_LOAD,  32'h0000_0007, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_access(ACT_STORE, 32'h0000_0003, 8'hFF, 64'h0123_4567_89AB_CDEF);
    send_access(ACT_LOAD,  32'h0000_0003, 8'h00, 64'h0000_0000_0000_0000);
    send_access(ACT_STORE, 32'h0000_0008, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF);
    send_access(ACT_LOAD,  32'h0000_000F, 8'h00, 64'h0000_0000_0000_0000);
    send_access(ACT_LOAD,  32'h0000_0200, 8'h00, 64'h1122_3344_5566_7788);
    send_access(ACT_LOAD,  32'h0000_0000, 8'h00, 64'h8877_6655_4433_2211);
    send_access(ACT_LOAD,  32'hFFFF_FFFF, 8'h00, 64'h0123_4567_89AB_CDEF);
    send_access(ACT_STORE, 32'hFFFF_FFF8, 8'h5A, 64'h0000_0000_0000_0000);
    send_access(ACT_LOAD,  32'hFFFF_FFF8, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF);
    send_access(ACT_STORE, 32'h7FFF_FFF9, 8'hA5, 64'hFEDC_BA98_7654_3210);
    send_access(ACT_LOAD,  32'h7FFF_FFF9, 8'h00, 64'h0000_0000_0000_0000);
    send_access(ACT_LOAD,  32'h8000_0000, 8'h00, 64'hAAAA_AAAA_AAAA_AAAA);
    send_access(ACT_STORE, 32'h5555_5555, 8'h55, 64'h5555_5555_5555_5555);
    send_access(ACT_LOAD,  32'hAAAA_AAAA, 8'hAA, 64'hAAAA_AAAA_AAAA_AAAA);
    idle_gap(3);
    send_access(ACT_STORE, 32'h5555_5555, 8'hC3, 64'h0000_0000_0000_0000);
    idle_gap(1);
    send_access(ACT_LOAD,  32'h5555_5555, 8'h00, 64'h0000_0000_0000_0000);

    for (int i = 0; i < 4; i++) begin
      tag_pool[i]  = 23'($urandom);
      hot_index[i] = 6'($urandom_range(63));
    end

    for (int i = 0; i < RandomAccesses; i++) begin
      idx = ($urandom_range(1) == 0) ? hot_index[2'($urandom_range(3))]
                                     : 6'($urandom_range(63));
      if ($urandom_range(99) < 75) begin
        addr = {tag_pool[2'($urandom_range(3))], idx, 3'($urandom_range(7))};
      end else begin
        addr = $urandom;
      end
      act = action_t'($urandom_range(1));
      send_access(act, addr, 8'($urandom_range(255)), {$urandom, $urandom});
      if ((i % 300) >= 60) begin
        idle_gap(pick_gap());
      end
    end

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ direct_mapped_write_through_cache_top.f @@
hdl/dmc_pkg.sv
hdl/dmc_counters.sv
hdl/direct_mapped_write_through_cache_top.sv
tb/direct_mapped_write_through_cache_checker.sv
tb/tb_direct_mapped_write_through_cache_top.sv
